[rtl/core/crctf_pkg.sv]
// Shared types, constants and the CRC-32 byte update of the trailer framer.
package crctf_pkg;

  // Trailer length in bytes and related widths
  localparam int TRAILER_BYTES = 4;
  localparam int HELD_W        = 3;
  localparam int RES_CNT_W     = 3;
  localparam int CRC_W         = 8 * TRAILER_BYTES;

  // Reflected CRC-32 polynomial and initial value
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam logic CFG_CRC_ENABLE = 1'b0;
  localparam logic CFG_DIRECTION  = 1'b1;

  // Direction codes
  localparam logic DIR_APPEND = 1'b0;
  localparam logic DIR_CHECK  = 1'b1;

  // Verdict codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // Results caused by one accepted beat: an optional payload result,
  // an optional four-byte trailer and an optional verdict result
  typedef struct packed {
    logic             pay_en;
    logic [7:0]       pay_data;
    logic             pay_valid;
    logic             pay_last;
    logic             trl_en;
    logic [CRC_W-1:0] trl_crc;
    logic             ver_en;
    logic [1:0]       ver_status;
  } bundle_t;

  // Advance the reflected CRC register by one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                input logic [7:0]       b);
    logic [CRC_W-1:0] c;
    c = c_in ^ {{(CRC_W-8){1'b0}}, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Number of results held in a bundle
  function automatic logic [RES_CNT_W-1:0] bundle_count(input bundle_t bnd);
    logic [RES_CNT_W-1:0] n;
    n = {{(RES_CNT_W-1){1'b0}}, bnd.pay_en}
      + (bnd.trl_en ? RES_CNT_W'(TRAILER_BYTES) : '0)
      + {{(RES_CNT_W-1){1'b0}}, bnd.ver_en};
    return n;
  endfunction

endpackage

[rtl/core/crctf_core.sv]
// Packet state, configuration registers and per-beat result bundle generation.
module crctf_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic                cfg_data,
  input  logic                accept,
  input  logic [7:0]          data_in,
  input  logic                has_byte,
  input  logic                end_of_packet,
  output logic                bnd_valid,
  output crctf_pkg::bundle_t  bnd
);

  logic                              crc_enable_r;
  logic                              direction_r;
  logic [crctf_pkg::CRC_W-1:0]       crc_r, crc_nxt;
  logic [7:0]                        dly_r [crctf_pkg::TRAILER_BYTES];
  logic [7:0]                        dly_nxt [crctf_pkg::TRAILER_BYTES];
  logic [crctf_pkg::HELD_W-1:0]      held_r, held_nxt;
  logic [crctf_pkg::CRC_W-1:0]       given;
  logic                              act;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_enable_r <= 1'b1;
      direction_r  <= crctf_pkg::DIR_APPEND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crctf_pkg::CFG_CRC_ENABLE: crc_enable_r <= cfg_data;
        crctf_pkg::CFG_DIRECTION:  direction_r  <= cfg_data;
      endcase
    end
  end

  // Work out next packet state and the results of this beat
  always_comb begin
    crc_nxt   = crc_r;
    dly_nxt   = dly_r;
    held_nxt  = held_r;
    bnd       = '0;
    act       = accept && (has_byte || end_of_packet);
    given     = '0;
    if (act) begin
      if (!crc_enable_r) begin
        // pass through unchanged
        bnd.pay_en    = 1'b1;
        bnd.pay_data  = has_byte ? data_in : 8'd0;
        bnd.pay_valid = has_byte;
        bnd.pay_last  = end_of_packet;
      end else if (direction_r == crctf_pkg::DIR_APPEND) begin
        if (has_byte) begin
          crc_nxt       = crctf_pkg::crc_byte(crc_r, data_in);
          bnd.pay_en    = 1'b1;
          bnd.pay_data  = data_in;
          bnd.pay_valid = 1'b1;
        end
        if (end_of_packet) begin
          bnd.trl_en  = 1'b1;
          bnd.trl_crc = ~crc_nxt;
        end
      end else begin
        // check mode: hold the newest bytes, release the oldest
        if (has_byte) begin
          if (held_r >= crctf_pkg::HELD_W'(crctf_pkg::TRAILER_BYTES)) begin
            crc_nxt       = crctf_pkg::crc_byte(crc_r, dly_r[0]);
            bnd.pay_en    = 1'b1;
            bnd.pay_data  = dly_r[0];
            bnd.pay_valid = 1'b1;
            for (int i = 0; i < crctf_pkg::TRAILER_BYTES - 1; i++) begin
              dly_nxt[i] = dly_r[i+1];
            end
            dly_nxt[crctf_pkg::TRAILER_BYTES-1] = data_in;
            held_nxt = crctf_pkg::HELD_W'(crctf_pkg::TRAILER_BYTES);
          end else begin
            dly_nxt[held_r[1:0]] = data_in;
            held_nxt = held_r + 1'b1;
          end
        end
        if (end_of_packet) begin
          for (int i = 0; i < crctf_pkg::TRAILER_BYTES; i++) begin
            given = {given[crctf_pkg::CRC_W-9:0], dly_nxt[i]};
          end
          bnd.ver_en = 1'b1;
          if (held_nxt < crctf_pkg::HELD_W'(crctf_pkg::TRAILER_BYTES)) begin
            bnd.ver_status = crctf_pkg::ST_SHORT;
          end else if (given == ~crc_nxt) begin
            bnd.ver_status = crctf_pkg::ST_OK;
          end else begin
            bnd.ver_status = crctf_pkg::ST_BAD;
          end
        end
      end
      // clear packet state at every end of packet
      if (end_of_packet) begin
        crc_nxt  = crctf_pkg::CRC_INIT;
        held_nxt = '0;
        for (int i = 0; i < crctf_pkg::TRAILER_BYTES; i++) begin
          dly_nxt[i] = 8'd0;
        end
      end
    end
    // hand on a bundle only when the beat causes at least one result
    bnd_valid = bnd.pay_en || bnd.trl_en || bnd.ver_en;
  end

  // Packet state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= crctf_pkg::CRC_INIT;
      held_r <= '0;
      for (int i = 0; i < crctf_pkg::TRAILER_BYTES; i++) begin
        dly_r[i] <= 8'd0;
      end
    end else begin
      crc_r  <= crc_nxt;
      held_r <= held_nxt;
      dly_r  <= dly_nxt;
    end
  end

endmodule

[rtl/core/crctf_out.sv]
// Result sequencer: bundle register with skid slot, one result per output beat.
module crctf_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                bnd_valid,
  input  crctf_pkg::bundle_t  bnd,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_data_out,
  output logic                out_byte_valid,
  output logic                out_last,
  output logic [1:0]          out_status
);

  crctf_pkg::bundle_t                  main_r, skid_r;
  logic                                main_valid_r, skid_valid_r;
  logic [crctf_pkg::RES_CNT_W-1:0]     idx_r;
  logic [crctf_pkg::RES_CNT_W-1:0]     tidx;
  logic [1:0]                          tsel;
  logic                                out_take, last_res, main_free;

  assign in_stall  = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_take  = main_valid_r && !out_stall;
  assign last_res  = (idx_r == crctf_pkg::bundle_count(main_r) - 1'b1);
  assign main_free = !main_valid_r || (out_take && last_res);

  // Select the current result of the bundle
  assign tidx = idx_r - {{(crctf_pkg::RES_CNT_W-1){1'b0}}, main_r.pay_en};
  assign tsel = 2'(crctf_pkg::TRAILER_BYTES - 1) - tidx[1:0];

  always_comb begin
    out_data_out   = 8'd0;
    out_byte_valid = 1'b0;
    out_last       = 1'b1;
    out_status     = crctf_pkg::ST_OK;
    if (main_r.pay_en && idx_r == '0) begin
      out_data_out   = main_r.pay_data;
      out_byte_valid = main_r.pay_valid;
      out_last       = main_r.pay_last;
    end else if (main_r.trl_en) begin
      out_data_out   = main_r.trl_crc[{tsel, 3'b000} +: 8];
      out_byte_valid = 1'b1;
      out_last       = (tidx == crctf_pkg::RES_CNT_W'(crctf_pkg::TRAILER_BYTES - 1));
    end else begin
      out_status     = main_r.ver_status;
    end
  end

  // Advance through the bundle, refill from skid slot or input
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
      idx_r        <= '0;
    end else if (main_free) begin
      idx_r <= '0;
      if (skid_valid_r) begin
        main_r       <= skid_r;
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else if (bnd_valid) begin
        main_r       <= bnd;
        main_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b0;
      end
    end else begin
      if (out_take) begin
        idx_r <= idx_r + 1'b1;
      end
      if (bnd_valid) begin
        skid_r       <= bnd;
        skid_valid_r <= 1'b1;
      end
    end
  end

endmodule

[rtl/core/crc32_trailer_framer.sv]
// Top level of the CRC-32 trailer framer.
// Takes one byte beat per cycle while in_stall is low and updates the CRC and
// trailer delay line in the cycle the beat is accepted; results then leave one per
// cycle while out_stall is low, through a bundle register backed by one skid slot.
// An end-of-packet beat causes up to five results in append mode
// (payload byte plus four trailer bytes, most significant first), up to two in
// check mode (released byte plus verdict), one in pass-through. No clearing
// pass follows reset.
module crc32_trailer_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_in,
  input  logic        in_has_byte,
  input  logic        in_end_of_packet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_out,
  output logic        out_byte_valid,
  output logic        out_last,
  output logic [1:0]  out_status
);

  logic                accept;
  logic                bnd_valid;
  crctf_pkg::bundle_t  bnd;

  assign accept = in_valid && !in_stall;

  // Packet state and result generation
  crctf_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .data_in       (in_data_in),
    .has_byte      (in_has_byte),
    .end_of_packet (in_end_of_packet),
    .bnd_valid     (bnd_valid),
    .bnd           (bnd)
  );

  // Result sequencing toward the output channel
  crctf_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .bnd_valid      (bnd_valid),
    .bnd            (bnd),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_out   (out_data_out),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_status     (out_status)
  );

endmodule

[tb/crc32_trailer_framer_tb.sv]
// Self-checking testbench for the CRC-32 trailer framer: append, check and pass-through.
module crc32_trailer_framer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY_WAIT = 12;
  localparam int STUCK_LIMIT  = 4000;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
    logic [1:0] status;
  } out_beat_t;

  // Shadow of the framer: CRC register, trailer delay line and the output beats it owes
  class crc_frame_tracker;
    logic                        enable;
    logic                        dir;
    logic [crctf_pkg::CRC_W-1:0] crc;
    logic [7:0]                  held [crctf_pkg::TRAILER_BYTES];
    int                          held_n;
    out_beat_t                   due [$];
    int                          errors;
    int                          beats_in;
    int                          beats_out;
    int                          verdicts [3];

    function new();
      enable = 1'b1;
      dir    = crctf_pkg::DIR_APPEND;
      errors = 0;
      beats_in  = 0;
      beats_out = 0;
      foreach (verdicts[i]) verdicts[i] = 0;
      clear_frame();
    endfunction

    // Shift one byte, LSB first, through the reflected polynomial
    static function logic [crctf_pkg::CRC_W-1:0] crc_advance(
      logic [crctf_pkg::CRC_W-1:0] c, logic [7:0] b);
      logic [crctf_pkg::CRC_W-1:0] r;
      r = c ^ crctf_pkg::CRC_W'(b);
      for (int k = 0; k < 8; k++)
        r = (r >> 1) ^ (crctf_pkg::CRC_POLY & {crctf_pkg::CRC_W{r[0]}});
      return r;
    endfunction

    function void clear_frame();
      crc    = crctf_pkg::CRC_INIT;
      held_n = 0;
      foreach (held[i]) held[i] = 8'h00;
    endfunction

    function void set_reg(logic idx, logic val);
      if (idx == crctf_pkg::CFG_CRC_ENABLE) enable = val;
      else dir = val;
    endfunction

    function void owe(logic [7:0] d, logic bv, logic lst, logic [1:0] st);
      due.push_back(out_beat_t'{data: d, byte_valid: bv, last: lst, status: st});
    endfunction

    // Work out the output beats caused by one accepted input beat
    function void take_beat(logic [7:0] d, logic hb, logic eop);
      logic [crctf_pkg::CRC_W-1:0] given;
      logic [1:0]                  verdict;
      if (!hb && !eop) return;
      beats_in++;
      if (!enable) begin
        owe(hb ? d : 8'h00, hb, eop, crctf_pkg::ST_OK);
      end else if (dir == crctf_pkg::DIR_APPEND) begin
        if (hb) begin
          crc = crc_advance(crc, d);
          owe(d, 1'b1, 1'b0, crctf_pkg::ST_OK);
        end
        if (eop) begin
          given = ~crc;
          for (int i = 0; i < crctf_pkg::TRAILER_BYTES; i++)
            owe(given[crctf_pkg::CRC_W-1-8*i -: 8], 1'b1,
                i == crctf_pkg::TRAILER_BYTES - 1, crctf_pkg::ST_OK);
        end
      end else begin
        // release the oldest held byte once the delay line is full
        if (hb) begin
          if (held_n == crctf_pkg::TRAILER_BYTES) begin
            crc = crc_advance(crc, held[0]);
            owe(held[0], 1'b1, 1'b0, crctf_pkg::ST_OK);
            for (int i = 0; i < crctf_pkg::TRAILER_BYTES - 1; i++) held[i] = held[i+1];
            held[crctf_pkg::TRAILER_BYTES-1] = d;
          end else begin
            held[held_n] = d;
            held_n++;
          end
        end
        if (eop) begin
          given = '0;
          for (int i = 0; i < crctf_pkg::TRAILER_BYTES; i++)
            given = {given[crctf_pkg::CRC_W-9:0], held[i]};
          if (held_n < crctf_pkg::TRAILER_BYTES) verdict = crctf_pkg::ST_SHORT;
          else if (given == ~crc) verdict = crctf_pkg::ST_OK;
          else verdict = crctf_pkg::ST_BAD;
          verdicts[verdict]++;
          owe(8'h00, 1'b0, 1'b1, verdict);
        end
      end
      if (eop) clear_frame();
    endfunction

    task flag(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compare one accepted output beat with the oldest one owed
    task match_result(logic [7:0] d, logic bv, logic lst, logic [1:0] st);
      out_beat_t want;
      beats_out++;
      if (due.size() == 0) begin
        flag($sformatf("output beat %02h/%0b/%0b/%0d with nothing owed", d, bv, lst, st));
        return;
      end
      want = due.pop_front();
      if (d !== want.data)
        flag($sformatf("data_out %02h, wanted %02h", d, want.data));
      if (bv !== want.byte_valid)
        flag($sformatf("byte_valid %0b, wanted %0b", bv, want.byte_valid));
      if (lst !== want.last)
        flag($sformatf("last %0b, wanted %0b", lst, want.last));
      if (st !== want.status)
        flag($sformatf("status %0d, wanted %0d", st, want.status));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic       cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_in;
  logic       in_has_byte;
  logic       in_end_of_packet;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_data_out;
  logic       out_byte_valid;
  logic       out_last;
  logic [1:0] out_status;

  crc_frame_tracker board;
  int               send_idle_pct;
  int               recv_idle_pct;

  crc32_trailer_framer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_in       (in_data_in),
    .in_has_byte      (in_has_byte),
    .in_end_of_packet (in_end_of_packet),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_out     (out_data_out),
    .out_byte_valid   (out_byte_valid),
    .out_last         (out_last),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Check each accepted output beat, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.match_result(out_data_out, out_byte_valid, out_last, out_status);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // End the run when no beat moves on either side for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("no beat moved for %0d cycles", STUCK_LIMIT);
    $display("crc32_trailer_framer_tb: errors");
    $finish;
  end

  // Frame check sequence of a payload, as it goes on the wire
  function automatic logic [crctf_pkg::CRC_W-1:0] fcs_of(input logic [7:0] payload [$]);
    logic [crctf_pkg::CRC_W-1:0] c;
    c = crctf_pkg::CRC_INIT;
    foreach (payload[i]) c = crc_frame_tracker::crc_advance(c, payload[i]);
    return ~c;
  endfunction

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(logic [7:0] d, logic hb, logic eop);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_in       <= d;
    in_has_byte      <= hb;
    in_end_of_packet <= eop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_beat(d, hb, eop);
  endtask

  // Drop valid, wait for every owed beat, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic set_config(logic en, logic dir);
    cfg_we    <= 1'b1;
    cfg_index <= crctf_pkg::CFG_CRC_ENABLE;
    cfg_data  <= en;
    @(posedge clk);
    board.set_reg(crctf_pkg::CFG_CRC_ENABLE, en);
    cfg_index <= crctf_pkg::CFG_DIRECTION;
    cfg_data  <= dir;
    @(posedge clk);
    board.set_reg(crctf_pkg::CFG_DIRECTION, dir);
    cfg_we <= 1'b0;
  endtask

  // One packet with random content; in check mode mostly a correct trailer
  task automatic send_random_packet();
    logic [7:0]                  body [$];
    logic [crctf_pkg::CRC_W-1:0] fcs;
    logic                        split_end;
    int                          n;
    int                          pick;
    int                          k;
    n = ($urandom_range(9) == 0) ? $urandom_range(16) : $urandom_range(6);
    repeat (n) body.push_back(8'($urandom));
    if (board.enable && board.dir == crctf_pkg::DIR_CHECK) begin
      pick = $urandom_range(9);
      if (pick < 8) begin
        fcs = fcs_of(body);
        for (int i = 0; i < crctf_pkg::TRAILER_BYTES; i++)
          body.push_back(fcs[crctf_pkg::CRC_W-1-8*i -: 8]);
        // corrupt one bit somewhere in the frame
        if (pick == 7) begin
          k = $urandom_range(body.size() - 1);
          body[k] = body[k] ^ 8'(1 << $urandom_range(7));
        end
      end
    end
    split_end = (body.size() == 0) || ($urandom_range(3) == 0);
    foreach (body[i]) begin
      if ($urandom_range(11) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(body[i], 1'b1, (i == body.size() - 1) && !split_end);
    end
    if (split_end) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic run_directed();
    logic [crctf_pkg::CRC_W-1:0] fcs;
    // append under reset settings: idle beat, empty packet, extreme bytes
    send_beat(8'h5A, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hA5, 1'b1, 1'b1);
    settle();
    set_config(1'b1, crctf_pkg::DIR_CHECK);
    // check: empty and short packets
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat(8'h12, 1'b1, 1'b0);
    send_beat(8'h34, 1'b1, 1'b1);
    // check: bare all-zero trailer matches an empty payload
    repeat (3) send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    // check: one payload byte with its correct trailer
    fcs = ~crc_frame_tracker::crc_advance(crctf_pkg::CRC_INIT, 8'h80);
    send_beat(8'h80, 1'b1, 1'b0);
    for (int i = 0; i < crctf_pkg::TRAILER_BYTES; i++)
      send_beat(fcs[crctf_pkg::CRC_W-1-8*i -: 8], 1'b1, i == crctf_pkg::TRAILER_BYTES - 1);
    // check: wrong trailer
    repeat (3) send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b1);
    // switch to append inside a packet; held byte must vanish
    send_beat(8'h11, 1'b1, 1'b0);
    settle();
    set_config(1'b1, crctf_pkg::DIR_APPEND);
    send_beat(8'h22, 1'b1, 1'b1);
    settle();
    set_config(1'b0, crctf_pkg::DIR_CHECK);
    // pass-through: empty packet and single byte
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hC3, 1'b1, 1'b1);
    settle();
  endtask

  initial begin
    int start_beats;
    board            = new();
    send_idle_pct    = 20;
    recv_idle_pct    = 59;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= crctf_pkg::CFG_CRC_ENABLE;
    cfg_data         <= 1'b0;
    in_valid         <= 1'b0;
    in_data_in       <= 8'h00;
    in_has_byte      <= 1'b0;
    in_end_of_packet <= 1'b0;
    out_stall        <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    // random packets under three idle profiles, four settings each
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 59 : 0;
      recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 20 : 0;
      for (int sub = 0; sub < 4; sub++) begin
        settle();
        case (sub)
          0: begin
            set_config(1'b1, crctf_pkg::DIR_APPEND);
          end
          1: begin
            set_config(1'b1, crctf_pkg::DIR_CHECK);
          end
          2: begin
            set_config(1'b0, 1'($urandom_range(1)));
          end
          default: begin
            set_config(1'($urandom_range(1)), 1'($urandom_range(1)));
          end
        endcase
        start_beats = board.beats_in;
        while (board.beats_in - start_beats < 10) send_random_packet();
      end
    end
    settle();

    $display("covered %0d input beats and %0d output beats in append, check and pass-through",
             board.beats_in, board.beats_out);
    $display("check verdicts seen: ok %0d, short %0d, bad crc %0d",
             board.verdicts[crctf_pkg::ST_OK], board.verdicts[crctf_pkg::ST_SHORT],
             board.verdicts[crctf_pkg::ST_BAD]);
    if (board.errors == 0 && board.due.size() == 0) begin
      $display("crc32_trailer_framer_tb: clean");
    end else begin
      $display("crc32_trailer_framer_tb: errors");
    end
    $finish;
  end

endmodule
